/* rtl/modular_exponentiation_macros.svh */
// Assertion macros shared by the modular exponentiation RTL
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ME_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/modexp_pkg.sv */
// Package: constants, register indexes and sequencer states for modular exponentiation
`timescale 1ns / 1ps

package modexp_pkg;

	localparam int WIDTH_DEFAULT = 32;
	localparam int FIELD_W       = 32;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_SQR,
		S_MUL,
		S_OUT
	} state_t;

endpackage

/* rtl/modular_exponentiation.sv */
// Modular exponentiation: result = message ** exponent mod modulus, one shared modular adder.
// An item is taken when start is high and busy is low; the result appears for one cycle
// with done high and cannot be held off. Operands are used at OW = min(WIDTH, 32) bits.
// All arithmetic runs through one modular adder, one add per cycle: a modular multiply
// does one doubling per bit of its multiplier plus one add per set bit. An item takes the
// reduction of the message (one such multiply by the message), plus for each of the OW
// exponent bits one squaring and, where the bit is set, one multiply by the base. With
// modulus zero the item goes straight to output with modulus_error set and result zero.
`timescale 1ns / 1ps

`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
	parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [modexp_pkg::FIELD_W-1:0]       message,
	output logic                                 done,
	output logic [modexp_pkg::FIELD_W-1:0]       result,
	output logic                                 modulus_error,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [modexp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [modexp_pkg::FIELD_W-1:0]       cfg_data
);

	localparam int OW = (WIDTH < modexp_pkg::FIELD_W) ? WIDTH : modexp_pkg::FIELD_W;
	localparam int CW = $clog2(OW);
	localparam logic [CW-1:0] CNT_TOP = CW'(OW - 1);

	modexp_pkg::state_t state_q, state_d;

	logic [OW-1:0] exp_cfg_q, mod_cfg_q;
	logic [OW-1:0] acc_q, mul_a_q, mul_b_q;
	logic [OW-1:0] base_q, pacc_q, exp_q;
	logic [CW-1:0] bcnt_q, ecnt_q;
	logic          phase_q, phase_d;
	logic          err_q;

	logic          in_mul;
	logic          step_adv, mul_last, exp_adv;
	logic [OW-1:0] add_y, gap, sum, init_one;
	logic          accept;
	logic [modexp_pkg::FIELD_W-1:0] mod_ext;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign mod_ext   = modexp_pkg::FIELD_W'(mod_cfg_q);

	// shared modular adder: (acc + y) mod m, both operands below m
	assign add_y = phase_q ? mul_a_q : acc_q;
	assign gap   = mod_cfg_q - add_y;
	assign sum   = (acc_q >= gap) ? (acc_q - gap) : (acc_q + add_y);

	assign init_one = (mod_cfg_q == OW'(1)) ? '0 : OW'(1);

	assign in_mul   = (state_q == modexp_pkg::S_RED) || (state_q == modexp_pkg::S_SQR) ||
		(state_q == modexp_pkg::S_MUL);
	// a multiplier bit is finished after its doubling (bit clear) or its add
	assign step_adv = in_mul && (phase_q || !mul_b_q[OW-1]);
	assign mul_last = step_adv && (bcnt_q == '0);
	assign exp_adv  = mul_last && (((state_q == modexp_pkg::S_SQR) && !exp_q[OW-1]) ||
		(state_q == modexp_pkg::S_MUL));
	assign phase_d  = in_mul && !phase_q && mul_b_q[OW-1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			modexp_pkg::S_IDLE: begin
				if (start) begin
					state_d = (mod_cfg_q == '0) ? modexp_pkg::S_OUT : modexp_pkg::S_RED;
				end
			end
			modexp_pkg::S_RED: begin
				if (mul_last) begin
					state_d = modexp_pkg::S_SQR;
				end
			end
			modexp_pkg::S_SQR: begin
				if (mul_last) begin
					if (exp_q[OW-1]) begin
						state_d = modexp_pkg::S_MUL;
					end else if (ecnt_q == '0) begin
						state_d = modexp_pkg::S_OUT;
					end else begin
						state_d = modexp_pkg::S_SQR;
					end
				end
			end
			modexp_pkg::S_MUL: begin
				if (mul_last) begin
					state_d = (ecnt_q == '0) ? modexp_pkg::S_OUT : modexp_pkg::S_SQR;
				end
			end
			modexp_pkg::S_OUT: begin
				state_d = modexp_pkg::S_IDLE;
			end
			default: begin
				state_d = modexp_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy          = 1'b1;
		done          = 1'b0;
		result        = '0;
		modulus_error = 1'b0;
		case (state_q)
			modexp_pkg::S_IDLE: begin
				busy = 1'b0;
			end
			modexp_pkg::S_OUT: begin
				done          = 1'b1;
				result        = err_q ? '0 : modexp_pkg::FIELD_W'(pacc_q);
				modulus_error = err_q;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= modexp_pkg::S_IDLE;
			phase_q   <= 1'b0;
			bcnt_q    <= '0;
			ecnt_q    <= '0;
			err_q     <= 1'b0;
			exp_cfg_q <= OW'(1);
			mod_cfg_q <= OW'(1);
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					modexp_pkg::REG_EXPONENT: exp_cfg_q <= cfg_data[OW-1:0];
					modexp_pkg::REG_MODULUS:  mod_cfg_q <= cfg_data[OW-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				err_q  <= (mod_cfg_q == '0);
				bcnt_q <= CNT_TOP;
				ecnt_q <= CNT_TOP;
			end else begin
				if (mul_last) begin
					bcnt_q <= CNT_TOP;
				end else if (step_adv) begin
					bcnt_q <= bcnt_q - CW'(1);
				end
				if (exp_adv) begin
					ecnt_q <= ecnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mul_a_q <= OW'(1);
			mul_b_q <= message[OW-1:0];
			acc_q   <= '0;
			exp_q   <= exp_cfg_q;
			pacc_q  <= '0;
		end else if (in_mul) begin
			if (mul_last) begin
				acc_q <= '0;
				if (exp_adv) begin
					exp_q <= exp_q << 1;
				end
				if (state_q == modexp_pkg::S_RED) begin
					base_q  <= sum;
					pacc_q  <= init_one;
					mul_a_q <= init_one;
					mul_b_q <= init_one;
				end else begin
					pacc_q  <= sum;
					mul_a_q <= sum;
					mul_b_q <= (state_d == modexp_pkg::S_MUL) ? base_q : sum;
				end
			end else begin
				acc_q <= sum;
				if (step_adv) begin
					mul_b_q <= mul_b_q << 1;
				end
			end
		end
	end

	`ME_ASSERT_NEXT(a_done_single, done, !done, "done strobe longer than one cycle")
	`ME_ASSERT_NEXT(a_accept_busy, accept, busy, "block not busy after taking an item")
	`ME_ASSERT_SAME(a_err_zero, done && modulus_error, result == '0, "error result not zero")
	`ME_ASSERT_SAME(a_res_range, done && !modulus_error, result < mod_ext, "result not reduced")
	`ME_ASSERT_SAME(a_acc_range, phase_q, acc_q < mod_cfg_q, "accumulator out of range")

endmodule
